[rtl/ffba_pkg.sv]
// ffba_pkg: shared constants and types for the first-fit block allocator
// no dependencies
`default_nettype none
package ffba_pkg;
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W = 10;
   localparam int CAP_W = 11;
   localparam int MAX_LIST = 32;
   localparam int LEN_W = 6;
   localparam int VALUE_WIDTH = 32;
   localparam logic [CAP_W-1:0] MIN_CAPACITY = 11'd8;

   localparam logic [2:0] FUNC_ALLOC = 3'd0;
   localparam logic [2:0] FUNC_DATA  = 3'd1;
   localparam logic [2:0] FUNC_FREE  = 3'd2;
   localparam logic [2:0] FUNC_PRINT = 3'd3;
   localparam logic [2:0] FUNC_USAGE = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_NO_DATA  = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]      address_out;
      logic [VALUE_WIDTH-1:0] value_out;
      logic                   value_valid;
      logic [CAP_W-1:0]       used_count;
      logic [CAP_W-1:0]       capacity_out;
      logic [1:0]             status;
      logic                   last;
   } rsp_type;
endpackage
`default_nettype wire

[rtl/first_fit_block_allocator_top.sv]
// first_fit_block_allocator_top: sequencer over the word store and occupied map
// depends on ffba_pkg
//
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_func, req_list_length, req_* fields
//  rsp     | out | rsp_valid, rsp_stall, rsp_* fields
//
// one request at a time; a walk step is a read state followed by an evaluate state.
// alloc: a first-fit pass over the capacity, a new pass after each doubling
// (from 8 up to 1024 words), then the reserve writes of n+1 words.
// free: clears the header's len+1 words, then scans from capacity/4; usage scans to capacity.
// print: reads each block word after the header; data word and unknown func answer the cycle after.
// after reset a clearing pass over all STORE_DEPTH words runs before requests are taken.
// a stalled response holds in the output register; the engine waits at its next response.
`default_nettype none
module first_fit_block_allocator_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [2:0]                             req_func,
   input  wire logic [ffba_pkg::LEN_W-1:0]             req_list_length,
   input  wire logic signed [ffba_pkg::VALUE_WIDTH-1:0] req_data_value,
   input  wire logic [ffba_pkg::ADDR_W-1:0]            req_block_address,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [ffba_pkg::ADDR_W-1:0]                 rsp_address_out,
   output logic signed [ffba_pkg::VALUE_WIDTH-1:0]     rsp_value_out,
   output logic                                        rsp_value_valid,
   output logic [ffba_pkg::CAP_W-1:0]                  rsp_used_count,
   output logic [ffba_pkg::CAP_W-1:0]                  rsp_capacity_out,
   output logic [1:0]                                  rsp_status,
   output logic                                        rsp_last
);
   localparam int AW = ffba_pkg::ADDR_W;
   localparam int CW = ffba_pkg::CAP_W;
   localparam int VW = ffba_pkg::VALUE_WIDTH;
   localparam int LW = ffba_pkg::LEN_W;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_FF_RD   = 4'd2;
   localparam logic [3:0] S_FF_EV   = 4'd3;
   localparam logic [3:0] S_RESV    = 4'd4;
   localparam logic [3:0] S_HDR_RD  = 4'd5;
   localparam logic [3:0] S_HDR_EV  = 4'd6;
   localparam logic [3:0] S_WALK_RD = 4'd7;
   localparam logic [3:0] S_WALK_EV = 4'd8;
   localparam logic [3:0] S_SHR_RD  = 4'd9;
   localparam logic [3:0] S_SHR_EV  = 4'd10;
   localparam logic [3:0] S_USE_RD  = 4'd11;
   localparam logic [3:0] S_USE_EV  = 4'd12;
   localparam logic [3:0] S_RSP     = 4'd13;

   logic [VW-1:0] store_mem [ffba_pkg::STORE_DEPTH];
   logic          occ_mem   [ffba_pkg::STORE_DEPTH];
   logic [VW-1:0] store_q;
   logic          occ_q;

   logic          st_we, oc_we, oc_wd;
   logic [AW-1:0] st_wa, oc_wa, rd_a;
   logic [VW-1:0] st_wd;

   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_wa] <= st_wd;
      if (oc_we) occ_mem[oc_wa] <= oc_wd;
      store_q <= store_mem[rd_a];
      occ_q <= occ_mem[rd_a];
   end

   logic [3:0]    state_ff, state_in;
   logic [2:0]    func_ff, func_in;
   logic [LW-1:0] len_ff, len_in;
   logic [VW-1:0] val_ff, val_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] fp_ff, fp_in;
   logic [LW-1:0] pend_ff, pend_in;
   logic [CW-1:0] i_ff, i_in;     // walk base
   logic [CW-1:0] j_ff, j_in;     // probe / cursor
   logic [CW-1:0] end_ff, end_in; // walk end (inclusive bound+1)
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          any_ff, any_in;
   logic          rv_ff, rv_in;
   ffba_pkg::rsp_type rsp_ff, rsp_in;

   logic          take;
   logic          out_free;
   logic [LW-1:0] clamp_len;
   logic [LW-1:0] sl;
   logic [CW:0]   tmp;
   ffba_pkg::rsp_type zr;

   assign take = (state_ff == S_IDLE) && req_valid && !rv_ff;
   assign req_stall = !((state_ff == S_IDLE) && !rv_ff);
   assign out_free = !rv_ff || !rsp_stall;
   assign clamp_len = (req_list_length > LW'(ffba_pkg::MAX_LIST)) ?
                      LW'(ffba_pkg::MAX_LIST) : req_list_length;
   assign sl = (store_q > VW'(ffba_pkg::MAX_LIST)) ? LW'(ffba_pkg::MAX_LIST)
                                                     : store_q[LW-1:0];

   always_comb begin
      zr = '0;
      state_in = state_ff; func_in = func_ff; len_in = len_ff; val_in = val_ff;
      cap_in = cap_ff; fp_in = fp_ff; pend_in = pend_ff; i_in = i_ff; j_in = j_ff;
      end_in = end_ff; cnt_in = cnt_ff; any_in = any_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      st_we = 1'b0; oc_we = 1'b0; oc_wd = 1'b0; st_wa = '0; oc_wa = '0; st_wd = '0;
      rd_a = '0; tmp = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            oc_we = 1'b1; oc_wa = i_ff[AW-1:0];
            st_we = 1'b1; st_wa = i_ff[AW-1:0];
            i_in = i_ff + 1'b1;
            if (i_ff == CW'(ffba_pkg::STORE_DEPTH - 1)) begin
               i_in = '0; state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               func_in = req_func; len_in = clamp_len; val_in = req_data_value;
               i_in = '0; j_in = '0; cnt_in = '0; any_in = 1'b0;
               rsp_in = zr; rsp_in.last = 1'b1;
               case (req_func)
                  ffba_pkg::FUNC_ALLOC: begin
                     pend_in = '0; state_in = S_FF_RD;
                  end
                  ffba_pkg::FUNC_DATA: begin
                     if (pend_ff == '0) rsp_in.status = ffba_pkg::ST_NO_DATA;
                     else begin
                        st_we = 1'b1; st_wa = fp_ff; st_wd = req_data_value;
                        fp_in = fp_ff + 1'b1; pend_in = pend_ff - 1'b1;
                     end
                     rv_in = 1'b1;
                  end
                  ffba_pkg::FUNC_FREE, ffba_pkg::FUNC_PRINT: begin
                     if (req_func == ffba_pkg::FUNC_FREE) pend_in = '0;
                     i_in = CW'(req_block_address);
                     if (CW'(req_block_address) < cap_ff) state_in = S_HDR_RD;
                     else rv_in = 1'b1;
                  end
                  ffba_pkg::FUNC_USAGE: state_in = S_USE_RD;
                  default: rv_in = 1'b1;
               endcase
            end
         end
         S_FF_RD: begin
            // i = run start, j = probe
            if (i_ff >= cap_ff) begin
               if (cap_ff < CW'(ffba_pkg::STORE_DEPTH)) begin
                  cap_in = cap_ff << 1; i_in = '0; j_in = '0;
               end else begin
                  rsp_in = zr; rsp_in.last = 1'b1;
                  rsp_in.status = ffba_pkg::ST_NO_SPACE;
                  state_in = S_RSP;
               end
            end else if (j_ff >= cap_ff) begin
               i_in = j_ff;
            end else begin
               rd_a = j_ff[AW-1:0]; state_in = S_FF_EV;
            end
         end
         S_FF_EV: begin
            state_in = S_FF_RD;
            if (occ_q) begin
               i_in = j_ff + CW'(sl) + 1'b1; j_in = j_ff + CW'(sl) + 1'b1;
            end else if (j_ff - i_ff == CW'(len_ff)) begin
               j_in = i_ff; state_in = S_RESV;
            end else j_in = j_ff + 1'b1;
         end
         S_RESV: begin
            oc_we = 1'b1; oc_wd = 1'b1; oc_wa = j_ff[AW-1:0];
            st_we = 1'b1; st_wa = j_ff[AW-1:0];
            st_wd = (j_ff == i_ff) ? VW'(len_ff) : '0;
            j_in = j_ff + 1'b1;
            if (j_ff - i_ff == CW'(len_ff)) begin
               fp_in = i_ff[AW-1:0] + 1'b1; pend_in = len_ff;
               rsp_in = zr; rsp_in.last = 1'b1; rsp_in.address_out = i_ff[AW-1:0];
               state_in = S_RSP;
            end
         end
         S_HDR_RD: begin
            rd_a = i_ff[AW-1:0]; state_in = S_HDR_EV;
         end
         S_HDR_EV: begin
            if (!occ_q) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               tmp = {1'b0, i_ff} + (CW+1)'(sl) + 1'b1;
               end_in = (tmp > (CW+1)'(cap_ff)) ? cap_ff : tmp[CW-1:0];
               if (func_ff == ffba_pkg::FUNC_FREE) begin
                  j_in = i_ff; state_in = S_WALK_EV;
               end else begin
                  j_in = i_ff + 1'b1; state_in = S_WALK_RD;
               end
            end
         end
         S_WALK_RD: begin
            if (j_ff >= end_ff) begin
               if (out_free) begin
                  rsp_in = zr; rsp_in.last = 1'b1;
                  if (any_ff) begin
                     rsp_in.value_out = val_ff; rsp_in.value_valid = 1'b1;
                  end
                  rv_in = 1'b1; state_in = S_IDLE;
               end
            end else begin
               rd_a = j_ff[AW-1:0]; state_in = S_WALK_EV;
            end
         end
         S_WALK_EV: begin
            if (func_ff == ffba_pkg::FUNC_FREE) begin
               if (j_ff >= end_ff) begin
                  j_in = cap_ff >> 2; state_in = S_SHR_RD;
               end else begin
                  oc_we = 1'b1; oc_wa = j_ff[AW-1:0]; j_in = j_ff + 1'b1;
               end
            end else begin
               // a found value is parked until the next one or the end is known
               rd_a = j_ff[AW-1:0];
               if (!occ_q) begin
                  j_in = j_ff + 1'b1; state_in = S_WALK_RD;
               end else if (!any_ff) begin
                  val_in = store_q; any_in = 1'b1;
                  j_in = j_ff + 1'b1; state_in = S_WALK_RD;
               end else if (out_free) begin
                  rsp_in = zr; rsp_in.value_out = val_ff; rsp_in.value_valid = 1'b1;
                  rv_in = 1'b1; val_in = store_q;
                  j_in = j_ff + 1'b1; state_in = S_WALK_RD;
               end
            end
         end
         S_SHR_RD: begin
            if (j_ff >= cap_ff) begin
               if (cap_ff > ffba_pkg::MIN_CAPACITY) cap_in = cap_ff >> 1;
               rsp_in = zr; rsp_in.last = 1'b1; state_in = S_RSP;
            end else begin
               rd_a = j_ff[AW-1:0]; state_in = S_SHR_EV;
            end
         end
         S_SHR_EV: begin
            if (occ_q) begin
               rsp_in = zr; rsp_in.last = 1'b1; state_in = S_RSP;
            end else begin
               j_in = j_ff + 1'b1; state_in = S_SHR_RD;
            end
         end
         S_USE_RD: begin
            if (j_ff >= cap_ff) begin
               rsp_in = zr; rsp_in.last = 1'b1;
               rsp_in.used_count = cnt_ff; rsp_in.capacity_out = cap_ff;
               state_in = S_RSP;
            end else begin
               rd_a = j_ff[AW-1:0]; state_in = S_USE_EV;
            end
         end
         S_USE_EV: begin
            cnt_in = cnt_ff + CW'(occ_q); j_in = j_ff + 1'b1; state_in = S_USE_RD;
         end
         S_RSP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cap_ff <= ffba_pkg::MIN_CAPACITY; fp_ff <= '0;
         pend_ff <= '0; i_ff <= '0; j_ff <= '0; rv_ff <= 1'b0; any_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cap_ff <= cap_in; fp_ff <= fp_in; pend_ff <= pend_in;
         i_ff <= i_in; j_ff <= j_in; rv_ff <= rv_in; any_ff <= any_in;
      end
      func_ff <= func_in; len_ff <= len_in; val_ff <= val_in; end_ff <= end_in;
      cnt_ff <= cnt_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_address_out = rsp_ff.address_out;
   assign rsp_value_out = rsp_ff.value_out;
   assign rsp_value_valid = rsp_ff.value_valid;
   assign rsp_used_count = rsp_ff.used_count;
   assign rsp_capacity_out = rsp_ff.capacity_out;
   assign rsp_status = rsp_ff.status;
   assign rsp_last = rsp_ff.last;
endmodule
`default_nettype wire
